@@ rtl/lddw_pkg.sv @@
package lddw_pkg;

  // default number of segment digits sent after the address command
  localparam int DIGITS_DEF = 4;

  // protocol command bytes
  localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
  localparam logic [7:0] CMD_ADDR_ZERO = 8'hC0;

  // register reset values
  localparam logic [7:0] DISP_CTRL_RST = 8'h88;
  localparam logic [7:0] TPP_RST       = 8'h01;

  // register map
  localparam int          CFG_AW        = 3;
  localparam logic        REG_DISP_CTRL = 1'b0;
  localparam logic        REG_TPP       = 1'b1;

  // request commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // byte part: eight bit groups of three phases plus a trailing clock-pin pulse
  localparam int BYTE_PHASES = 27;
  localparam int BIT_PHASES  = 24;
  localparam int EDGE_PHASES = 4;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_BYTE,
    KIND_STOP
  } lddw_kind_t;

  // result of one request
  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic busy;
    logic refused;
  } lddw_res_t;

endpackage

@@ rtl/lddw_cfg.sv @@
module lddw_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lddw_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [7:0]                 disp_ctrl,
  output logic [7:0]                 tpp
);
  import lddw_pkg::*;

  logic [7:0] disp_ctrl_r;
  logic [7:0] tpp_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // register writes, word decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_ctrl_r <= DISP_CTRL_RST;
      tpp_r       <= TPP_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DISP_CTRL: disp_ctrl_r <= pwdata[7:0];
        REG_TPP:       tpp_r       <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (reg_sel)
      REG_DISP_CTRL: prdata = {24'b0, disp_ctrl_r};
      REG_TPP:       prdata = {24'b0, tpp_r};
      default:       prdata = '0;
    endcase
  end

  assign disp_ctrl = disp_ctrl_r;
  assign tpp       = tpp_r;

endmodule

@@ rtl/lddw_seq.sv @@
module lddw_seq #(
  parameter int DIGITS = lddw_pkg::DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_en,
  input  logic                cmd,
  input  logic [31:0]         seg,
  input  logic [7:0]          disp_ctrl,
  input  logic [7:0]          tpp,
  output lddw_pkg::lddw_res_t res
);
  import lddw_pkg::*;

  localparam int LAST   = 9 + DIGITS;
  localparam int STEP_W = $clog2(LAST + 1);
  localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int SEG_W  = 8 * ((DIGITS > 4) ? DIGITS : 4);

  localparam logic [STEP_W-1:0] ST_IDLE   = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_START1 = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_BYTE1  = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_STOP1  = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_START2 = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_ADDR   = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_DIG0   = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_STOP2  = STEP_W'(6 + DIGITS);
  localparam logic [STEP_W-1:0] ST_START3 = STEP_W'(7 + DIGITS);
  localparam logic [STEP_W-1:0] ST_LAST   = STEP_W'(LAST);

  logic [7:0]        digit_r [DIGITS];
  logic [7:0]        shift_r,  shift_nxt;
  logic [STEP_W-1:0] step_r,   step_nxt;
  logic [4:0]        pos_r,    pos_nxt;
  logic [1:0]        ph_r,     ph_nxt;
  logic [7:0]        timer_r,  timer_nxt;
  logic              clk_r,    clk_nxt;
  logic              dio_r,    dio_nxt;
  logic              busy_r,   busy_nxt;
  logic              refused;
  logic              load_ok;
  logic              drive;
  logic [SEG_W-1:0]  seg_ext;
  logic [7:0]        limit;
  logic [8:0]        timer_inc;
  logic [4:0]        pos_inc;
  logic [4:0]        part_len;
  logic [STEP_W-1:0] step_inc;
  lddw_kind_t        drv_kind;

  function automatic lddw_kind_t part_kind(input logic [STEP_W-1:0] s);
    if (s == ST_START1 || s == ST_START2 || s == ST_START3) return KIND_START;
    if (s == ST_STOP1 || s == ST_STOP2 || s == ST_LAST) return KIND_STOP;
    return KIND_BYTE;
  endfunction

  function automatic logic [7:0] part_byte(input logic [STEP_W-1:0] s,
                                           input logic [7:0] dc);
    logic [STEP_W-1:0] off;
    off = s - ST_DIG0;
    if (s == ST_BYTE1) return CMD_DATA_AUTO;
    if (s == ST_ADDR) return CMD_ADDR_ZERO;
    if (s >= ST_DIG0 && s < ST_STOP2) return digit_r[off[IDX_W-1:0]];
    return dc;
  endfunction

  assign seg_ext   = SEG_W'(seg);
  assign limit     = (tpp == 8'd0) ? 8'd1 : tpp;
  assign timer_inc = {1'b0, timer_r} + 9'd1;
  assign pos_inc   = pos_r + 5'd1;
  assign step_inc  = step_r + STEP_W'(1);
  assign part_len  = (part_kind(step_r) == KIND_BYTE) ? 5'(BYTE_PHASES) : 5'(EDGE_PHASES);
  assign load_ok   = (cmd == CMD_LOAD) && !busy_r;

  // next state for one request
  always_comb begin
    shift_nxt = shift_r;
    step_nxt  = step_r;
    pos_nxt   = pos_r;
    ph_nxt    = ph_r;
    timer_nxt = timer_r;
    clk_nxt   = clk_r;
    dio_nxt   = dio_r;
    busy_nxt  = busy_r;
    refused   = 1'b0;
    drive     = 1'b0;
    if (cmd == CMD_LOAD) begin
      if (busy_r) begin
        refused = 1'b1;
      end else begin
        busy_nxt  = 1'b1;
        timer_nxt = 8'd0;
        step_nxt  = ST_START1;
        pos_nxt   = 5'd0;
        ph_nxt    = 2'd0;
        drive     = 1'b1;
      end
    end else if (busy_r) begin
      if (timer_inc >= {1'b0, limit}) begin
        timer_nxt = 8'd0;
        if (pos_inc < part_len) begin
          pos_nxt = pos_inc;
          ph_nxt  = (ph_r == 2'd2) ? 2'd0 : ph_r + 2'd1;
          drive   = 1'b1;
        end else if (step_r >= ST_LAST) begin
          step_nxt = ST_IDLE;
          pos_nxt  = 5'd0;
          busy_nxt = 1'b0;
        end else begin
          step_nxt = step_inc;
          pos_nxt  = 5'd0;
          ph_nxt   = 2'd0;
          drive    = 1'b1;
          if (part_kind(step_inc) == KIND_BYTE) begin
            shift_nxt = part_byte(step_inc, disp_ctrl);
          end
        end
      end else begin
        timer_nxt = timer_inc[7:0];
      end
    end

    // pin phase for the new position
    drv_kind = part_kind(step_nxt);
    if (drive) begin
      case (drv_kind)
        KIND_START: begin
          case (pos_nxt)
            5'd0:    clk_nxt = 1'b1;
            5'd1:    dio_nxt = 1'b1;
            5'd2:    dio_nxt = 1'b0;
            default: clk_nxt = 1'b0;
          endcase
        end
        KIND_STOP: begin
          case (pos_nxt)
            5'd0:    clk_nxt = 1'b0;
            5'd1:    dio_nxt = 1'b0;
            5'd2:    clk_nxt = 1'b1;
            default: dio_nxt = 1'b1;
          endcase
        end
        default: begin
          if (pos_nxt < 5'(BIT_PHASES)) begin
            case (ph_nxt)
              2'd0: clk_nxt = 1'b0;
              2'd1: begin
                dio_nxt   = shift_r[0];
                shift_nxt = {1'b0, shift_r[7:1]};
              end
              default: clk_nxt = 1'b1;
            endcase
          end else if (pos_nxt == 5'(BIT_PHASES + 1)) begin
            clk_nxt = 1'b1;
          end else begin
            clk_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 8'd0;
      step_r  <= ST_IDLE;
      pos_r   <= 5'd0;
      ph_r    <= 2'd0;
      timer_r <= 8'd0;
      clk_r   <= 1'b0;
      dio_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else if (item_en) begin
      shift_r <= shift_nxt;
      step_r  <= step_nxt;
      pos_r   <= pos_nxt;
      ph_r    <= ph_nxt;
      timer_r <= timer_nxt;
      clk_r   <= clk_nxt;
      dio_r   <= dio_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // segment store, digits past the fourth load as zero
  always_ff @(posedge clk) begin
    if (item_en && load_ok) begin
      for (int i = 0; i < DIGITS; i++) begin
        digit_r[i] <= seg_ext[8*i +: 8];
      end
    end
  end

  assign res.clk_level = clk_nxt;
  assign res.dio_level = dio_nxt;
  assign res.busy      = busy_nxt;
  assign res.refused   = refused;

endmodule

@@ rtl/led_driver_two_wire_writer.sv @@
// Two-wire LED driver writer. A load request latches DIGITS segment bytes and
// starts three transactions (data command, address command with the digits,
// display control), each a start, LSB-first bytes with a trailing pulse on
// the clock pin and a stop; every following tick request advances the pins by
// at most one phase, each phase held for ticks_per_phase ticks. One request is
// accepted every clock cycle while in_stall is low: the request is registered,
// the sequencer updates its state and computes the pin levels in a single pass,
// and the result register holds them until taken. A load while busy is
// dropped and flagged in load_refused.
module led_driver_two_wire_writer #(
  parameter int DIGITS = lddw_pkg::DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [31:0]                in_segment_bytes,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_clk_level,
  output logic                       out_dio_level,
  output logic                       out_busy_res,
  output logic                       out_load_refused,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lddw_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lddw_pkg::*;

  logic        in_v_r;
  logic        cmd_r;
  logic [31:0] seg_r;
  logic        out_v_r;
  lddw_res_t   res_r;
  lddw_res_t   res_nxt;
  logic        move;
  logic        in_take;
  logic [7:0]  disp_ctrl;
  logic [7:0]  tpp;

  // move the held request into the result register when there is room
  assign move     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !move;
  assign in_take  = in_valid && !in_stall;

  lddw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .disp_ctrl (disp_ctrl),
    .tpp       (tpp)
  );

  lddw_seq #(
    .DIGITS (DIGITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_en   (move),
    .cmd       (cmd_r),
    .seg       (seg_r),
    .disp_ctrl (disp_ctrl),
    .tpp       (tpp),
    .res       (res_nxt)
  );

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (move) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= in_command;
      seg_r <= in_segment_bytes;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (move) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_clk_level    = res_r.clk_level;
  assign out_dio_level    = res_r.dio_level;
  assign out_busy_res     = res_r.busy;
  assign out_load_refused = res_r.refused;

endmodule

@@ rtl/lddw_chk.sv @@
module lddw_chk (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_clk_level,
  input logic out_dio_level,
  input logic out_busy_res,
  input logic out_load_refused
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_clk_level) &&
    $stable(out_dio_level) && $stable(out_busy_res) && $stable(out_load_refused))
    else $error("stalled result changed");

  // a refused load only happens while a sequence runs
  a_refuse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_load_refused |-> out_busy_res)
    else $error("load refused while idle");

  // idle pins are both low after reset or both high after a stop
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_clk_level == out_dio_level)
    else $error("idle pins not at a bus-free level");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind led_driver_two_wire_writer lddw_chk u_lddw_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_clk_level    (out_clk_level),
  .out_dio_level    (out_dio_level),
  .out_busy_res     (out_busy_res),
  .out_load_refused (out_load_refused)
);
